>>> hw/rtl/sdt_pkg.sv
`default_nettype none

package sdt_pkg;

    localparam int DELIM_MAX       = 8;
    localparam int IDX_W           = $clog2(DELIM_MAX);
    localparam int CNT_W           = $clog2(DELIM_MAX + 1);
    localparam int WORD_COUNT_BITS = 16;
    localparam int QDEPTH          = 2;
    localparam int PTR_W           = $clog2(QDEPTH);

    localparam logic KIND_WORD = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic CFG_DELIM_LENGTH = 1'b0;
    localparam logic CFG_DELIM_BYTES  = 1'b1;

    typedef enum logic {
        OP_BYTE      = 1'b0,
        OP_LAST_BYTE = 1'b1
    } sdt_op_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } sdt_in_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  out_byte;
        logic        word_start;
        logic [15:0] word_number;
        logic        last;
    } sdt_out_t;

    typedef struct packed {
        sdt_op_t    op;
        logic [7:0] data;
    } sdt_cmd_t;

    typedef struct packed {
        logic     valid;
        sdt_cmd_t cmd;
    } sdt_qif_t;

    typedef struct packed {
        logic [3:0]  delim_length;
        logic [63:0] delim_bytes;
    } sdt_cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/sdt_front.sv
`default_nettype none

module sdt_front import sdt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire sdt_in_t  in_item,
    output sdt_qif_t      q,
    input  wire logic     take
);

    sdt_cmd_t             mem_reg [QDEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]       cnt_reg, cnt_next;
    logic                 do_push;
    logic                 do_pop;
    sdt_cmd_t             cmd_in;

    assign full    = (cnt_reg == (PTR_W + 1)'(QDEPTH));
    assign do_push = push && !full;
    assign do_pop  = take && (cnt_reg != '0);

    always_comb
    begin
        cmd_in.op   = in_item.end_of_string ? OP_LAST_BYTE : OP_BYTE;
        cmd_in.data = in_item.in_byte;
    end

    always_comb
    begin
        q.valid     = (cnt_reg != '0);
        q.cmd       = mem_reg[rd_ptr_reg];
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/sdt_engine.sv
`default_nettype none

module sdt_engine import sdt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire sdt_cfg_t cfg,
    input  wire sdt_qif_t cmd_q,
    output logic          cmd_take,
    input  wire logic     res_room,
    output logic          res_wr,
    output sdt_out_t      res
);

    logic [7:0]                 win_reg [DELIM_MAX];
    logic [7:0]                 win_next [DELIM_MAX];
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       gap_reg, gap_next;
    logic [WORD_COUNT_BITS-1:0] wcnt_reg, wcnt_next;
    logic                       busy_reg, busy_next;
    logic                       eos_reg, eos_next;

    always_comb
    begin
        logic [7:0]                 a [DELIM_MAX];
        logic [CNT_W-1:0]           ca;
        logic                       eos_a;
        logic [CNT_W-1:0]           len;
        logic [DELIM_MAX-1:0]       m;
        logic                       go;
        logic                       run;
        logic                       run_after;
        logic                       end_sent;
        logic                       chain_ok;
        logic [CNT_W-1:0]           shift;
        logic [CNT_W-1:0]           c_after;
        logic [6:0]                 s;
        logic [WORD_COUNT_BITS-1:0] wnew;

        len = (cfg.delim_length > CNT_W'(DELIM_MAX)) ? CNT_W'(DELIM_MAX)
                                                     : CNT_W'(cfg.delim_length);

        cmd_take = !busy_reg && cmd_q.valid && res_room;
        go       = res_room && (busy_reg || cmd_q.valid);

        a     = win_reg;
        ca    = count_reg;
        eos_a = eos_reg;
        if (!busy_reg)
        begin
            a[count_reg[IDX_W-1:0]] = cmd_q.cmd.data;
            ca    = count_reg + 1'b1;
            eos_a = (cmd_q.cmd.op == OP_LAST_BYTE);
        end

        for (int o = 0; o < DELIM_MAX; o++)
        begin
            m[o] = ((CNT_W + 1)'(o) + (CNT_W + 1)'(len) <= (CNT_W + 1)'(ca));
            for (int i = 0; i < DELIM_MAX; i++)
            begin
                if (o + i < DELIM_MAX)
                begin
                    if ((CNT_W'(i) < len) && (a[o + i] != cfg.delim_bytes[8 * i +: 8]))
                    begin
                        m[o] = 1'b0;
                    end
                end
            end
        end

        run = (len == '0) ? (ca != '0) : (ca >= len);

        chain_ok = 1'b1;
        for (int k = 0; k < DELIM_MAX; k++)
        begin
            s = 7'd1 + 7'(k) * 7'(len);
            if ((s + 7'(len) <= 7'(ca)) && !m[s[IDX_W-1:0]])
            begin
                chain_ok = 1'b0;
            end
        end

        win_next   = win_reg;
        count_next = count_reg;
        gap_next   = gap_reg;
        wcnt_next  = wcnt_reg;
        busy_next  = busy_reg;
        eos_next   = eos_reg;
        res_wr     = 1'b0;
        res        = '0;
        shift      = '0;
        c_after    = ca;
        end_sent   = 1'b0;
        run_after  = 1'b0;
        wnew       = wcnt_reg;

        if (go)
        begin
            eos_next = eos_a;
            if (run && (len != '0) && m[0])
            begin
                shift    = len;
                c_after  = ca - len;
                gap_next = 1'b1;
            end
            else if (run || (eos_a && (ca != '0)))
            begin
                shift   = CNT_W'(1);
                c_after = ca - 1'b1;
                if (gap_reg)
                begin
                    if (wcnt_reg != '1)
                    begin
                        wnew = wcnt_reg + 1'b1;
                    end
                    gap_next = 1'b0;
                end
                wcnt_next       = wnew;
                res_wr          = 1'b1;
                res.kind        = KIND_WORD;
                res.out_byte    = a[0];
                res.word_start  = gap_reg;
                res.word_number = 16'(wnew - 1'b1);
                if (eos_a)
                begin
                    res.last = 1'b0;
                end
                else if (len == '0)
                begin
                    res.last = (c_after == '0);
                end
                else
                begin
                    res.last = chain_ok;
                end
            end
            else if (eos_a)
            begin
                c_after         = '0;
                gap_next        = 1'b1;
                wcnt_next       = '0;
                end_sent        = 1'b1;
                res_wr          = 1'b1;
                res.kind        = KIND_END;
                res.word_number = 16'(wcnt_reg);
                res.last        = 1'b1;
            end

            for (int i = 0; i < DELIM_MAX; i++)
            begin
                win_next[i] = a[i];
                for (int n = 1; n <= DELIM_MAX; n++)
                begin
                    if (i + n < DELIM_MAX)
                    begin
                        if (shift == CNT_W'(n))
                        begin
                            win_next[i] = a[i + n];
                        end
                    end
                end
            end

            count_next = c_after;
            run_after  = (len == '0) ? (c_after != '0) : (c_after >= len);
            busy_next  = !end_sent && (run_after || eos_a);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            gap_reg   <= 1'b1;
            wcnt_reg  <= '0;
            busy_reg  <= 1'b0;
            eos_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            gap_reg   <= gap_next;
            wcnt_reg  <= wcnt_next;
            busy_reg  <= busy_next;
            eos_reg   <= eos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/sdt_outq.sv
`default_nettype none

module sdt_outq import sdt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     wr,
    input  wire sdt_out_t data,
    output logic          room,
    output logic          empty,
    input  wire logic     pop,
    output sdt_out_t      out_item
);

    sdt_out_t         mem_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   cnt_reg, cnt_next;
    logic             do_wr;
    logic             do_pop;

    assign room     = (cnt_reg != (PTR_W + 1)'(QDEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_wr    = wr && room;
    assign do_pop   = pop && !empty;
    assign out_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= data;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/substring_delimiter_tokenizer.sv
// Channel   Handshake               Beat
// input     push / full             in_item   : in_byte, end_of_string
// result    pop / empty             out_item  : kind, out_byte, word_start,
//                                               word_number, last
// config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One byte per cycle sustained while the result queue has room and no drain
// runs; the window engine does one compare-and-emit or one delimiter drop per
// cycle. Input stalls while a final byte drains, one result or dropped delimiter
// at a time. A window left longer than a newly written delimiter drains one step
// per cycle. Two-beat queues sit on both sides; a full result queue stalls the
// engine. Reset is asynchronous, active low; no clearing pass is needed.
`default_nettype none

module substring_delimiter_tokenizer import sdt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire sdt_in_t     in_item,
    output logic             empty,
    input  wire logic        pop,
    output sdt_out_t         out_item,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [63:0] cfg_data
);

    logic [3:0]  delim_length_reg;
    logic [63:0] delim_bytes_reg;
    sdt_cfg_t    cfg;
    sdt_qif_t    cmd_q;
    logic        cmd_take;
    logic        res_room;
    logic        res_wr;
    sdt_out_t    res;

    assign cfg_ready        = 1'b1;
    assign cfg.delim_length = delim_length_reg;
    assign cfg.delim_bytes  = delim_bytes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_length_reg <= '0;
            delim_bytes_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DELIM_LENGTH: delim_length_reg <= cfg_data[3:0];
                CFG_DELIM_BYTES:  delim_bytes_reg  <= cfg_data;
                default:          delim_length_reg <= delim_length_reg;
            endcase
        end
    end

    sdt_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_item (in_item),
        .q       (cmd_q),
        .take    (cmd_take)
    );

    sdt_engine u_engine
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cmd_q    (cmd_q),
        .cmd_take (cmd_take),
        .res_room (res_room),
        .res_wr   (res_wr),
        .res      (res)
    );

    sdt_outq u_outq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (res_wr),
        .data     (res),
        .room     (res_room),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

    a_end_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (out_item.kind == KIND_END)) |->
            (out_item.last && !out_item.word_start && (out_item.out_byte == 8'd0)))
        else $error("end marker malformed");

    a_result_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_wr |-> res_room)
        else $error("result written into a full queue");

    a_full_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("input queue filled without a push");

    a_take_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> cmd_q.valid)
        else $error("engine took from an empty queue");

endmodule

`default_nettype wire

>>> dv/tb_substring_delimiter_tokenizer.sv
`default_nettype none

module tb_substring_delimiter_tokenizer;
    import sdt_pkg::*;

    localparam int SETTLE_CYCLES = 32;
    localparam int CYCLE_LIMIT   = 3_000_000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        push      = 1'b0;
    logic        full;
    sdt_in_t     in_item   = '0;
    logic        empty;
    logic        pop       = 1'b0;
    sdt_out_t    out_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_DELIM_LENGTH;
    logic [63:0] cfg_data  = '0;

    substring_delimiter_tokenizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // tokenizer state as the block should hold it
    logic [3:0]  delim_len_q = '0;
    logic [63:0] delim_q     = '0;
    logic [7:0]  pending [DELIM_MAX];
    int unsigned pending_cnt = 0;
    bit          between_words = 1'b1;
    logic [15:0] words_started = '0;

    sdt_out_t    expected_beats [$];
    int unsigned err_count      = 0;
    int unsigned src_gap_max    = 13;
    int unsigned sink_stall_max = 13;
    int unsigned pop_hold       = 0;
    int unsigned cycles         = 0;

    function automatic int unsigned delim_span();
        return (delim_len_q > DELIM_MAX) ? DELIM_MAX : int'(delim_len_q);
    endfunction

    function automatic void drop_pending(input int unsigned n);
        if (n >= pending_cnt)
        begin
            pending_cnt = 0;
            return;
        end
        for (int i = 0; i + n < pending_cnt; i++)
        begin
            pending[i] = pending[i + n];
        end
        pending_cnt -= n;
    endfunction

    function automatic void emit_word_byte();
        sdt_out_t r;
        r            = '0;
        r.kind       = KIND_WORD;
        r.out_byte   = pending[0];
        r.word_start = between_words;
        if (between_words)
        begin
            if (words_started != 16'hFFFF)
                words_started++;
            between_words = 1'b0;
        end
        r.word_number = words_started - 16'd1;
        expected_beats.push_back(r);
        drop_pending(1);
    endfunction

    function automatic bit delim_at_front(input int unsigned len);
        for (int i = 0; i < len; i++)
        begin
            if (pending[i] != delim_q[8*i +: 8])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void tokenize_byte(input logic [7:0] b, input logic eos);
        int unsigned len;
        int unsigned before_n;
        sdt_out_t    r;
        len      = delim_span();
        before_n = expected_beats.size();
        if (pending_cnt >= DELIM_MAX)
            emit_word_byte();
        pending[pending_cnt] = b;
        pending_cnt++;
        if (len == 0)
        begin
            while (pending_cnt > 0)
                emit_word_byte();
        end
        else
        begin
            while (pending_cnt >= len)
            begin
                if (delim_at_front(len))
                begin
                    drop_pending(len);
                    between_words = 1'b1;
                end
                else
                begin
                    emit_word_byte();
                end
            end
        end
        if (eos)
        begin
            while (pending_cnt > 0)
                emit_word_byte();
            r             = '0;
            r.kind        = KIND_END;
            r.word_number = words_started;
            expected_beats.push_back(r);
            pending_cnt   = 0;
            between_words = 1'b1;
            words_started = '0;
        end
        if (expected_beats.size() > before_n)
        begin
            r      = expected_beats.pop_back();
            r.last = 1'b1;
            expected_beats.push_back(r);
        end
    endfunction

    function automatic void check_beat(input sdt_out_t got);
        sdt_out_t want;
        if (expected_beats.size() == 0)
        begin
            err_count++;
            if (err_count <= 10)
                $display("unexpected beat: kind=%0d byte=%02h start=%0d word=%0d last=%0d",
                         got.kind, got.out_byte, got.word_start, got.word_number, got.last);
            return;
        end
        want = expected_beats.pop_front();
        if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
            got.word_start !== want.word_start || got.word_number !== want.word_number ||
            got.last !== want.last)
        begin
            err_count++;
            if (err_count <= 10)
                $display("mismatch: expected kind=%0d byte=%02h start=%0d word=%0d last=%0d, %s",
                         want.kind, want.out_byte, want.word_start, want.word_number,
                         want.last,
                         $sformatf("got kind=%0d byte=%02h start=%0d word=%0d last=%0d",
                                   got.kind, got.out_byte, got.word_start,
                                   got.word_number, got.last));
        end
    endfunction

    always @(posedge clk)
    begin
        int unsigned w;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                check_beat(out_item);
                w = $urandom_range(0, sink_stall_max);
                if (w != 0)
                begin
                    pop      <= 1'b0;
                    pop_hold <= w;
                end
            end
            else if (pop_hold > 1)
            begin
                pop_hold <= pop_hold - 1;
            end
            else
            begin
                pop      <= 1'b1;
                pop_hold <= 0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_substring_delimiter_tokenizer: errors");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eos);
        int unsigned gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_item <= '{in_byte: b, end_of_string: eos};
        push    <= 1'b1;
        do
            @(posedge clk);
        while (full);
        tokenize_byte(b, eos);
    endtask

    // hold input until every expected beat is out and the block has settled
    task automatic drain_results();
        push <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [63:0] val);
        drain_results();
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_DELIM_LENGTH)
            delim_len_q = val[3:0];
        else
            delim_q = val;
    endtask

    task automatic send_string(input int unsigned n, input bit close, output int unsigned sent);
        logic [7:0]  text [$];
        int unsigned pick;
        int unsigned k;
        int unsigned span;
        span = delim_span();
        while (text.size() < n)
        begin
            pick = $urandom_range(0, 9);
            if (span != 0 && pick < 3)
            begin
                for (int i = 0; i < span; i++)
                    text.push_back(delim_q[8*i +: 8]);
            end
            else if (span != 0 && pick < 7)
            begin
                k = $urandom_range(0, span - 1);
                text.push_back(delim_q[8*k +: 8]);
            end
            else
            begin
                text.push_back(8'($urandom_range(0, 255)));
            end
        end
        foreach (text[i])
        begin
            if (i == text.size() / 2 && $urandom_range(0, 15) == 0)
                drain_results();
            send_byte(text[i], close && (i == text.size() - 1));
        end
        sent = text.size();
    endtask

    task automatic test_no_delimiter();
        write_reg(CFG_DELIM_LENGTH, 64'd0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h5A, 1'b1);
    endtask

    task automatic test_delimiter_edges();
        logic [7:0] text [8] = '{8'h2C, 8'h2C, 8'h61, 8'h2C, 8'h2C, 8'h62, 8'h2C, 8'h2C};
        write_reg(CFG_DELIM_BYTES, 64'h2C);
        write_reg(CFG_DELIM_LENGTH, 64'd1);
        foreach (text[i])
            send_byte(text[i], i == 7);
        // over-long length clamps; the end flushes a nearly full window
        write_reg(CFG_DELIM_BYTES, {64{1'b1}});
        write_reg(CFG_DELIM_LENGTH, 64'd15);
        repeat (7) send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_register_change_mid_string();
        write_reg(CFG_DELIM_BYTES, 64'h62_6161);
        write_reg(CFG_DELIM_LENGTH, 64'd3);
        send_byte(8'h78, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h61, 1'b0);
        write_reg(CFG_DELIM_LENGTH, 64'd0);
        send_byte(8'h62, 1'b1);
    endtask

    task automatic test_random_strings();
        int unsigned sent;
        int unsigned chunk;
        logic [3:0]  len;
        logic [63:0] d;
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph)
                0: len = 4'd0;
                1: len = 4'd8;
                2: len = 4'd15;
                default: len = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(9, 15))
                                                            : 4'($urandom_range(1, 8));
            endcase
            if (ph == 3)
                d = {64{1'b1}};
            else if (ph == 4)
                d = '0;
            else if ($urandom_range(0, 1) == 0)
                d = {$urandom, $urandom};
            else
            begin
                for (int i = 0; i < 8; i++)
                    d[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 1));
            end
            write_reg(CFG_DELIM_BYTES, d);
            write_reg(CFG_DELIM_LENGTH, {60'd0, len});
            src_gap_max    = ($urandom_range(0, 2) == 0) ? 0 : 13;
            sink_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 13;
            sent = 0;
            while (sent < 36)
            begin
                // leave some phases with a string still open
                send_string($urandom_range(1, 12), (sent < 30) || (ph % 4 != 1), chunk);
                sent += chunk;
            end
        end
        src_gap_max    = 13;
        sink_stall_max = 13;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_no_delimiter();
        test_delimiter_edges();
        test_register_change_mid_string();
        test_random_strings();
        drain_results();
        if (err_count == 0 && expected_beats.size() == 0)
            $display("tb_substring_delimiter_tokenizer: clean");
        else
            $display("tb_substring_delimiter_tokenizer: errors");
        $finish;
    end

endmodule

`default_nettype wire
